>>> hdl/fla_pkg.sv
// ---------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free list allocator
// Widths, operation codes, status codes and sequencer states.
// ---------------------------------------------------------------------------
package fla_pkg;
  localparam int ARENA_UNITS_DEF = 4096;
  localparam int UNIT_BYTES_DEF  = 16;
  localparam int AW = 12;
  localparam int SW = 13;
  localparam int RW = 16;

  localparam logic [15:0] MAX_REQ_RST  = 16'd4096;
  localparam logic [12:0] MIN_GROW_RST = 13'd1024;

  typedef enum logic [0:0] {FUNC_ALLOC = 1'b0, FUNC_RELEASE = 1'b1} func_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NO_SPACE = 2'd1, ST_TOO_LARGE = 2'd2
  } status_t;
  typedef enum logic [0:0] {CFG_MAX_REQ = 1'b0, CFG_MIN_GROW = 1'b1} cfg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_AL_RD_LINK, S_AL_WAIT, S_AL_CHECK, S_AL_SPLIT,
    S_AL_GROW, S_RL_RD, S_RL_WAIT, S_RL_CHECK, S_RL_RD_HDR, S_RL_WAIT_HDR,
    S_RL_FWD, S_RL_RD_P, S_RL_WAIT_P, S_RL_BACK, S_DONE
  } state_t;

  typedef struct packed {
    logic        we;
    logic [15:0] waddr;
    logic [24:0] wdata;
    logic [15:0] raddr;
  } mem_ctl_t;
endpackage

>>> hdl/fla_if.sv
// ---------------------------------------------------------------------------
// fla_stream_if: valid/ready channel with a payload of parameter type
// ---------------------------------------------------------------------------
interface fla_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/fla_ram.sv
// ---------------------------------------------------------------------------
// fla_ram: generic simple dual port RAM with registered read
// ---------------------------------------------------------------------------
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/fla_seq.sv
// ---------------------------------------------------------------------------
// fla_seq: list walk sequencer
// Walks the free list one header at a time through one memory port.
// Each entry holds {size, link}; a shared adder (op_a + op_b) serves several states.
// ---------------------------------------------------------------------------
module fla_seq #(
  parameter int ARENA_UNITS = 4096,
  parameter int UNIT_BYTES  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                func,
  input  logic [15:0]         req,
  input  logic [11:0]         addr,
  input  logic [15:0]         max_req,
  input  logic [12:0]         min_grow,
  output logic                busy,
  output logic                done,
  output logic [1:0]          status,
  output logic [11:0]         granted,
  output fla_pkg::mem_ctl_t   mem_ctl,
  input  logic [24:0]         rdata
);
  import fla_pkg::*;
  localparam int MA = $clog2(ARENA_UNITS);
  localparam int PW = (MA > 13) ? MA + 2 : 15;
  localparam int LIM = 2 * ARENA_UNITS + 8;
  localparam int LW = $clog2(LIM + 2);
  localparam int UB = $clog2(UNIT_BYTES);

  state_t st_r, st_nxt;
  logic [PW-1:0] rover_r, rover_nxt, brk_r, brk_nxt;
  logic [PW-1:0] prev_r, prev_nxt, p_r, p_nxt, hdr_r, hdr_nxt, nx_r, nx_nxt;
  logic [PW-1:0] units_r, units_nxt;
  logic [12:0]   sz_r, sz_nxt, hsz_r, hsz_nxt;
  logic [LW-1:0] n_r, n_nxt;
  logic          grow_r, grow_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [11:0]   gr_r, gr_nxt;
  logic [MA:0]   clr_r, clr_nxt;
  logic [PW-1:0] sum;
  logic [PW-1:0] link_rd, op_a, op_b;
  logic [12:0]   size_rd;

  assign link_rd = PW'(rdata[11:0]);
  assign size_rd = rdata[24:12];
  assign sum = op_a + op_b;
  assign busy = (st_r != S_IDLE);
  assign done = (st_r == S_DONE);
  assign status = status_r;
  assign granted = gr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; rover_r <= '0; brk_r <= PW'(1); clr_r <= '0;
      status_r <= '0; gr_r <= '0; n_r <= '0; grow_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rover_r <= rover_nxt; brk_r <= brk_nxt; clr_r <= clr_nxt;
      status_r <= status_nxt; gr_r <= gr_nxt; n_r <= n_nxt; grow_r <= grow_nxt;
    end
    prev_r <= prev_nxt; p_r <= p_nxt; hdr_r <= hdr_nxt; nx_r <= nx_nxt;
    units_r <= units_nxt; sz_r <= sz_nxt; hsz_r <= hsz_nxt;
  end

  always_comb begin
    st_nxt = st_r; rover_nxt = rover_r; brk_nxt = brk_r; clr_nxt = clr_r;
    prev_nxt = prev_r; p_nxt = p_r; hdr_nxt = hdr_r; nx_nxt = nx_r;
    units_nxt = units_r; sz_nxt = sz_r; hsz_nxt = hsz_r; n_nxt = n_r;
    grow_nxt = grow_r; status_nxt = status_r; gr_nxt = gr_r;
    op_a = '0; op_b = '0;
    mem_ctl = '0;
    case (st_r)
      S_CLEAR: begin
        // zero entry 0 only; other entries are written before read
        mem_ctl.we = 1'b1;
        mem_ctl.waddr = '0;
        mem_ctl.wdata = '0;
        clr_nxt = clr_r + 1'b1;
        st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          status_nxt = ST_OK; gr_nxt = '0; n_nxt = '0; grow_nxt = 1'b0;
          if (func == FUNC_RELEASE) begin
            hdr_nxt = PW'(addr) - PW'(1);
            if (addr >= 12'd2 && (PW'(addr) - PW'(1)) < brk_r &&
                (PW'(addr) - PW'(1)) < PW'(ARENA_UNITS)) begin
              p_nxt = rover_r; st_nxt = S_RL_RD;
            end else st_nxt = S_DONE;
          end else if (req > max_req) begin
            status_nxt = ST_TOO_LARGE; st_nxt = S_DONE;
          end else begin
            units_nxt = PW'((({1'b0, req} + 17'(UNIT_BYTES - 1)) >> UB) + 17'd1);
            prev_nxt = rover_r; st_nxt = S_AL_RD_LINK;
          end
        end
      end
      S_AL_RD_LINK: begin
        mem_ctl.raddr = 16'(prev_r); st_nxt = S_AL_WAIT;
      end
      S_AL_WAIT: begin
        // rdata holds entry prev; link gives p
        p_nxt = link_rd;
        mem_ctl.raddr = 16'(link_rd);
        nx_nxt = link_rd;
        st_nxt = S_AL_CHECK;
        if (n_r >= LW'(LIM)) begin
          status_nxt = ST_NO_SPACE; st_nxt = S_DONE;
        end
      end
      S_AL_CHECK: begin
        // rdata holds entry p
        sz_nxt = size_rd; nx_nxt = link_rd;
        op_a = p_r; op_b = PW'(size_rd);
        if (PW'(size_rd) >= units_r && sum <= PW'(ARENA_UNITS)) begin
          rover_nxt = prev_r;
          if (PW'(size_rd) == units_r) begin
            // unlink p: rewrite prev's link, keep prev's size (re-read later)
            st_nxt = S_AL_SPLIT; sz_nxt = '0; gr_nxt = 12'(p_r + PW'(1));
            hsz_nxt = 13'd0;
          end else begin
            mem_ctl.we = 1'b1; mem_ctl.waddr = 16'(p_r);
            mem_ctl.wdata = {size_rd - 13'(units_r), link_rd[11:0]};
            p_nxt = p_r + PW'(size_rd - 13'(units_r));
            gr_nxt = 12'(p_r + PW'(size_rd - 13'(units_r)) + PW'(1));
            hsz_nxt = 13'd1; st_nxt = S_AL_SPLIT;
          end
        end else if (p_r == rover_r && !grow_r) begin
          st_nxt = S_AL_GROW;
        end else begin
          grow_nxt = 1'b0;
          prev_nxt = p_r; n_nxt = n_r + 1'b1;
          mem_ctl.raddr = 16'(link_rd); p_nxt = link_rd;
          st_nxt = S_AL_CHECK;
          // need prev's data only via p; keep walking
          if (n_r + 1'b1 >= LW'(LIM)) begin
            status_nxt = ST_NO_SPACE; st_nxt = S_DONE;
          end
        end
      end
      S_AL_SPLIT: begin
        if (hsz_r == 13'd1) begin
          mem_ctl.we = 1'b1; mem_ctl.waddr = 16'(p_r);
          mem_ctl.wdata = {13'(units_r), 12'd0};
          st_nxt = S_DONE;
        end else begin
          // exact fit: read prev to keep its size when rewriting link
          mem_ctl.raddr = 16'(prev_r);
          hsz_nxt = 13'd2; st_nxt = S_AL_SPLIT;
          if (hsz_r == 13'd2) begin
            mem_ctl.we = 1'b1; mem_ctl.waddr = 16'(prev_r);
            mem_ctl.wdata = {size_rd, nx_r[11:0]};
            st_nxt = S_DONE;
          end
        end
      end
      S_AL_GROW: begin
        op_a = brk_r;
        op_b = (units_r < PW'(min_grow)) ? PW'(min_grow) : units_r;
        if (sum > PW'(ARENA_UNITS - 1)) begin
          status_nxt = ST_NO_SPACE; st_nxt = S_DONE;
        end else begin
          mem_ctl.we = 1'b1; mem_ctl.waddr = 16'(brk_r);
          mem_ctl.wdata = {13'(op_b), 12'd0};
          hdr_nxt = brk_r; brk_nxt = sum; p_nxt = rover_r;
          grow_nxt = 1'b1; st_nxt = S_RL_RD;
        end
      end
      S_RL_RD: begin
        mem_ctl.raddr = 16'(p_r); st_nxt = S_RL_WAIT;
      end
      S_RL_WAIT: begin
        nx_nxt = link_rd; sz_nxt = size_rd; st_nxt = S_RL_CHECK;
      end
      S_RL_CHECK: begin
        if ((hdr_r > p_r && hdr_r < nx_r) ||
            (p_r >= nx_r && (hdr_r > p_r || hdr_r < nx_r))) begin
          mem_ctl.raddr = 16'(hdr_r); st_nxt = S_RL_WAIT_HDR;
        end else begin
          p_nxt = nx_r; n_nxt = n_r + 1'b1;
          st_nxt = S_RL_RD;
          if (n_r + 1'b1 > LW'(LIM)) st_nxt = grow_r ? S_AL_WAIT : S_DONE;
        end
      end
      S_RL_WAIT_HDR: begin
        hsz_nxt = size_rd; mem_ctl.raddr = 16'(nx_r); st_nxt = S_RL_FWD;
      end
      S_RL_FWD: begin
        // rdata holds entry nx
        op_a = hdr_r; op_b = PW'(hsz_r);
        mem_ctl.we = 1'b1; mem_ctl.waddr = 16'(hdr_r);
        if (sum[11:0] == nx_r[11:0] && (sum >> 12) == '0) begin
          hsz_nxt = hsz_r + size_rd;
          mem_ctl.wdata = {hsz_r + size_rd, link_rd[11:0]};
          nx_nxt = link_rd;
        end else begin
          mem_ctl.wdata = {hsz_r, nx_r[11:0]};
        end
        st_nxt = S_RL_BACK;
      end
      S_RL_BACK: begin
        op_a = p_r; op_b = PW'(sz_r);
        mem_ctl.we = 1'b1; mem_ctl.waddr = 16'(p_r);
        if (sum == hdr_r) mem_ctl.wdata = {sz_r + hsz_r, nx_r[11:0]};
        else              mem_ctl.wdata = {sz_r, hdr_r[11:0]};
        rover_nxt = p_r;
        if (grow_r) begin
          prev_nxt = p_r; n_nxt = n_r + 1'b1; st_nxt = S_AL_RD_LINK;
        end else st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!grow_r || status_r != ST_OK) st_nxt = S_IDLE;
        else st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end
  logic unused;
  assign unused = ^{clr_r, S_RL_RD_HDR, S_RL_RD_P, S_RL_WAIT_P};
endmodule

>>> hdl/free_list_allocator_top.sv
// ---------------------------------------------------------------------------
// free_list_allocator_top: next-fit free list allocator
//   channel | dir | payload
//   in_     | in  | func, request_bytes, block_address
//   out_    | out | status, granted_address
//   cfg_    | in  | index, data
// One request at a time; the walk visits one free block at a time, and
// splitting, merging or growth add more steps; the header RAM sets the pace.
// After reset the S_CLEAR state writes the sentinel entry before requests are taken.
// The result is held in an output register until taken; no new request
// is accepted while it waits.
// ---------------------------------------------------------------------------
module free_list_allocator_top #(
  parameter int ARENA_UNITS = fla_pkg::ARENA_UNITS_DEF,
  parameter int UNIT_BYTES  = fla_pkg::UNIT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fla_stream_if.sink  in_ch,
  fla_stream_if.source out_ch,
  fla_stream_if.sink  cfg_ch
);
  import fla_pkg::*;
  localparam int MA = $clog2(ARENA_UNITS);

  logic [15:0] max_req_r;
  logic [12:0] min_grow_r;
  logic        busy, done, out_v_r;
  logic [1:0]  status, out_st_r;
  logic [11:0] granted, out_ga_r;
  mem_ctl_t    mc;
  logic [24:0] rdata;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= MAX_REQ_RST; min_grow_r <= MIN_GROW_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data[16] == CFG_MAX_REQ) max_req_r <= cfg_ch.data[15:0];
      else                                 min_grow_r <= cfg_ch.data[12:0];
    end
  end

  assign in_ch.ready = !busy && !out_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (done) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
    if (done) begin
      out_st_r <= status; out_ga_r <= granted;
    end
  end
  assign out_ch.valid = out_v_r;
  assign out_ch.data = {out_st_r, out_ga_r};

  fla_seq #(.ARENA_UNITS(ARENA_UNITS), .UNIT_BYTES(UNIT_BYTES)) u_seq (
    .clk, .rst_n,
    .start(in_ch.valid && in_ch.ready),
    .func(in_ch.data[28]), .req(in_ch.data[27:12]), .addr(in_ch.data[11:0]),
    .max_req(max_req_r), .min_grow(min_grow_r),
    .busy, .done, .status, .granted, .mem_ctl(mc), .rdata
  );

  fla_ram #(.WIDTH(25), .DEPTH(ARENA_UNITS)) u_ram (
    .clk, .we(mc.we), .waddr(mc.waddr[MA-1:0]), .wdata(mc.wdata),
    .raddr(mc.raddr[MA-1:0]), .rdata
  );
endmodule

>>> hdl/fla_checker.sv
// ---------------------------------------------------------------------------
// fla_checker: port-level checks of the allocator
// ---------------------------------------------------------------------------
module fla_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("overlap");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data[13:12] != 2'd3) else $error("status");
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[13:12] != 2'd0 |-> out_data[11:0] == 12'd0) else $error("addr");
endmodule

bind free_list_allocator_top fla_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

>>> tb/tb_fla_if_types.sv
// ---------------------------------------------------------------------------
// tb_fla_types: payload types for the allocator channels
// Request, answer and register-write payloads carried by fla_stream_if.
// ---------------------------------------------------------------------------
package tb_fla_types;
  import fla_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [15:0] request_bytes;
    logic [11:0] block_address;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] granted_address;
  } rsp_t;

  typedef struct packed {
    cfg_idx_t    index;
    logic [15:0] data;
  } cfg_t;
endpackage

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: regression bench for the next-fit free list allocator
// A shadow allocator predicts every answer; requests come in bursts, the
// answer side stalls, and register settings change between drained phases.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fla_pkg::*;
  import tb_fla_types::*;

  localparam int UNITS = 4096;
  localparam int UBYTES = 16;
  localparam int WALK_MAX = 2 * UNITS + 8;

  class alloc_scoreboard;
    int unsigned link_mem[UNITS];
    int unsigned size_mem[UNITS];
    int unsigned rover, brk, max_req, min_grow;
    rsp_t pending[$];
    int errors, n_ok, n_full, n_big, n_rel;

    function void reset_state();
      foreach (link_mem[i]) begin
        link_mem[i] = 0;
        size_mem[i] = 0;
      end
      rover = 0;
      brk = 1;
      max_req = 4096;
      min_grow = 1024;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] v);
      if (idx == CFG_MAX_REQ) max_req = v;
      else min_grow = v & 16'h1FFF;
    endfunction

    function void insert_free(int unsigned hdr);
      int unsigned p, nx, n;
      p = rover;
      n = 0;
      forever begin
        nx = link_mem[p];
        if (hdr > p && hdr < nx) break;
        if (p >= nx && (hdr > p || hdr < nx)) break;
        p = nx;
        n++;
        if (n > WALK_MAX) return;
      end
      if (hdr + size_mem[hdr] == nx) begin
        size_mem[hdr] = (size_mem[hdr] + size_mem[nx]) & 13'h1FFF;
        link_mem[hdr] = link_mem[nx];
      end else link_mem[hdr] = nx;
      if (p + size_mem[p] == hdr) begin
        size_mem[p] = (size_mem[p] + size_mem[hdr]) & 13'h1FFF;
        link_mem[p] = link_mem[hdr];
      end else link_mem[p] = hdr;
      rover = p;
    endfunction

    function rsp_t allocate(int unsigned req);
      rsp_t r;
      int unsigned units, prev, p, sz, nu, up;
      r.status = ST_OK;
      r.granted_address = 0;
      if (req > max_req) begin
        r.status = ST_TOO_LARGE;
        return r;
      end
      units = (req + UBYTES - 1) / UBYTES + 1;
      prev = rover;
      p = link_mem[prev];
      for (int n = 0; n < WALK_MAX; n++) begin
        sz = size_mem[p];
        if (sz >= units && p + sz <= UNITS) begin
          if (sz == units) link_mem[prev] = link_mem[p];
          else begin
            sz -= units;
            size_mem[p] = sz;
            p += sz;
            size_mem[p] = units;
          end
          rover = prev;
          r.granted_address = (p + 1) & 12'hFFF;
          return r;
        end
        if (p == rover) begin
          nu = units < min_grow ? min_grow : units;
          if (brk + nu > UNITS - 1) begin
            r.status = ST_NO_SPACE;
            return r;
          end
          up = brk;
          size_mem[up] = nu & 13'h1FFF;
          brk += nu;
          insert_free(up);
          p = rover;
        end
        prev = p;
        p = link_mem[p];
      end
      r.status = ST_NO_SPACE;
      return r;
    endfunction

    // Predict the answer to an accepted request and queue it.
    function rsp_t note_request(req_t q);
      rsp_t r;
      if (q.func == FUNC_RELEASE) begin
        r.status = ST_OK;
        r.granted_address = 0;
        n_rel++;
        if (q.block_address >= 2 && q.block_address - 1 < brk)
          insert_free(q.block_address - 1);
      end else begin
        r = allocate(q.request_bytes);
        case (r.status)
          ST_OK: n_ok++;
          ST_NO_SPACE: n_full++;
          default: n_big++;
        endcase
      end
      pending.push_back(r);
      return r;
    endfunction

    function void check_answer(rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected answer status=%0d addr=%0d", $time, a.status,
                 a.granted_address);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.granted_address !== e.granted_address) begin
        $display("%0t: granted_address expected %0d actual %0d", $time,
                 e.granted_address, a.granted_address);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  fla_stream_if #(req_t) in_ch (clk);
  fla_stream_if #(rsp_t) out_ch (clk);
  fla_stream_if #(cfg_t) cfg_ch (clk);

  free_list_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  alloc_scoreboard sb = new();
  int unsigned held[$];
  int burst_left = 0;
  bit stall_free = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #400ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Answer side: stalls on a duty pattern, with stretches of full ready.
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_free <= ($urandom_range(0, 2) == 0);
    out_ch.ready <= stall_free || (stall_cnt % 7 < 4) || ($urandom_range(0, 3) == 0);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_answer(out_ch.data);
  end

  task automatic send_request(req_t q);
    rsp_t r;
    if (burst_left == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1;
    in_ch.data <= q;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    r = sb.note_request(q);
    if (q.func == FUNC_ALLOC && r.status == ST_OK) held.push_back(r.granted_address);
  endtask

  task automatic do_alloc(int unsigned bytes);
    req_t q;
    q.func = FUNC_ALLOC;
    q.request_bytes = bytes;
    q.block_address = $urandom;
    send_request(q);
  endtask

  task automatic do_release(int unsigned addr);
    req_t q;
    q.func = FUNC_RELEASE;
    q.request_bytes = $urandom;
    q.block_address = addr;
    send_request(q);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [15:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.data <= '{index: idx, data: v};
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, v);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic release_held();
    int k;
    k = $urandom_range(0, held.size() - 1);
    do_release(held[k]);
    held.delete(k);
  endtask

  task automatic random_phase(int count);
    int unsigned sel, a;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        a = $urandom_range(0, 9);
        if (a < 6) do_alloc($urandom_range(0, 256));
        else if (a < 9) do_alloc($urandom_range(0, 4096));
        else do_alloc($urandom);
      end else if (sel < 88 && held.size() > 0) release_held();
      else if (sel < 95) begin
        // bogus address: below the first block or past the break
        a = $urandom_range(0, 3);
        if (a == 0) do_release($urandom_range(0, 1));
        else if (sb.brk + 1 <= 4095) do_release($urandom_range(sb.brk + 1, 4095));
        else do_release(4095);
      end else if (held.size() > 0 && $urandom_range(0, 3) == 0) begin
        // double release of a live block, left on the held list
        do_release(held[$urandom_range(0, held.size() - 1)]);
      end else do_alloc($urandom_range(0, 64));
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    out_ch.ready = 0;
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: limits, operations, bad and repeated releases
    do_alloc(0);
    do_alloc(1);
    do_alloc(16);
    do_alloc(17);
    do_alloc(4096);
    do_alloc(4097);
    do_alloc(65535);
    do_release(0);
    do_release(1);
    do_release(4095);
    do_release(held[1]);
    do_release(held[1]);
    do_release(held[0]);
    do_release(held[2]);
    do_alloc(32);
    do_alloc(4000);
    do_alloc(4000);
    do_alloc(4000);
    drain();
    write_cfg(CFG_MAX_REQ, 16'hFFFF);
    write_cfg(CFG_MIN_GROW, 16'd1);
    do_alloc(65535);
    do_alloc(16'h8000);
    random_phase(250);
    drain();
    write_cfg(CFG_MAX_REQ, 16'd1);
    write_cfg(CFG_MIN_GROW, 16'd4096);
    do_alloc(1);
    do_alloc(2);
    random_phase(200);
    drain();
    write_cfg(CFG_MAX_REQ, $urandom_range(1, 65535));
    write_cfg(CFG_MIN_GROW, $urandom_range(1, 4096));
    random_phase(280);
    drain();

    $display("ran %0d grants, %0d out-of-space, %0d over-limit, %0d releases",
             sb.n_ok, sb.n_full, sb.n_big, sb.n_rel);
    $display("over four register settings, break ended at unit %0d", sb.brk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/fla_pkg.sv
hdl/fla_if.sv
hdl/fla_ram.sv
hdl/fla_seq.sv
hdl/free_list_allocator_top.sv
hdl/fla_checker.sv
tb/tb_fla_if_types.sv
tb/tb_top.sv
